// File: rtl/bakery_ticket_arbiter_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bakery ticket arbiter
// Clocked, reset-gated property checks; compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef BAKERY_TICKET_ARBITER_MACROS_SVH
`define BAKERY_TICKET_ARBITER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk and held off during reset.
`define BTA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk and held off during reset.
`define BTA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BTA_ASSERT_IMP(lbl, ante, cons, msg)
`define BTA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/bta_pkg.sv
// ---------------------------------------------------------------------------
// Bakery ticket arbiter package
// Shared constants, the controller state type and the scan control word.
// ---------------------------------------------------------------------------
`default_nettype none

package bta_pkg;

    localparam int DEF_PARTIES    = 32;
    localparam int DEF_TICKET_MAX = 255;
    localparam int PARTY_W        = 5;
    localparam int GIVEN_W        = 8;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Control part of the word that walks down the cell chain.
    typedef struct packed {
        logic               valid;
        logic               is_rel;
        logic [PARTY_W-1:0] party;
    } pass_ctl_t;

endpackage

`default_nettype wire

// File: rtl/bta_cell.sv
// ---------------------------------------------------------------------------
// Bakery ticket arbiter cell
// Holds one party's ticket and folds it into the scan word passing through.
// ---------------------------------------------------------------------------
`default_nettype none

module bta_cell #(
    parameter int TW      = 8,
    parameter int IW      = 5,
    parameter int CELL_ID = 0
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire  bta_pkg::pass_ctl_t     ctl_in,
    input  wire  [TW-1:0]                max_in,
    input  wire  [TW-1:0]                mina_in,
    input  wire  [IW-1:0]                mina_id_in,
    input  wire  [TW-1:0]                minx_in,
    input  wire  [IW-1:0]                minx_id_in,
    output bta_pkg::pass_ctl_t           ctl_out,
    output logic [TW-1:0]                max_out,
    output logic [TW-1:0]                mina_out,
    output logic [IW-1:0]                mina_id_out,
    output logic [TW-1:0]                minx_out,
    output logic [IW-1:0]                minx_id_out,
    input  wire                          wr_en,
    input  wire  [bta_pkg::PARTY_W-1:0]  wr_party,
    input  wire  [TW-1:0]                wr_value
);
    import bta_pkg::*;

    localparam int XW = (IW > PARTY_W) ? IW : PARTY_W;
    localparam logic [XW-1:0] MY_ID = XW'(CELL_ID);

    logic [TW-1:0] ticket_reg;
    pass_ctl_t     ctl_reg;
    logic [TW-1:0] max_reg, mina_reg, minx_reg;
    logic [IW-1:0] mina_id_reg, minx_id_reg;

    logic          is_self;
    logic          beats_all;
    logic          beats_ex;

    assign is_self   = (MY_ID == XW'(ctl_in.party));
    // Strict compare keeps the lower party on ties, since the chain runs upward.
    assign beats_all = (ticket_reg != '0) && ((mina_in == '0) || (ticket_reg < mina_in));
    assign beats_ex  = !is_self && (ticket_reg != '0) &&
                       ((minx_in == '0) || (ticket_reg < minx_in));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticket_reg <= '0;
            ctl_reg    <= '0;
        end
        else
        begin
            if (wr_en && (MY_ID == XW'(wr_party)))
            begin
                ticket_reg <= wr_value;
            end
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg        <= (ticket_reg > max_in) ? ticket_reg : max_in;
        mina_reg       <= beats_all ? ticket_reg : mina_in;
        mina_id_reg    <= beats_all ? IW'(CELL_ID) : mina_id_in;
        minx_reg       <= beats_ex ? ticket_reg : minx_in;
        minx_id_reg    <= beats_ex ? IW'(CELL_ID) : minx_id_in;
    end

    assign ctl_out     = ctl_reg;
    assign max_out     = max_reg;
    assign mina_out    = mina_reg;
    assign mina_id_out = mina_id_reg;
    assign minx_out    = minx_reg;
    assign minx_id_out = minx_id_reg;

endmodule

`default_nettype wire

// File: rtl/bakery_ticket_arbiter.sv
// ---------------------------------------------------------------------------
// Bakery ticket arbiter
// Ticket-based mutual exclusion: take-ticket and release words from up to
// PARTIES parties, each answered with the ticket granted and current holder.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake              Fields
//  --------  ---------------------  ------------------------------------------
//  event in  start && !busy         req_type, party_id
//  result    done (one cycle)       ticket_given, refused, holder_valid,
//                                   holder_id
//
//  Each event word walks the chain of ticket cells at one cell per cycle,
//  and its result word is on the outputs for one cycle after the last
//  cell. A new event can be accepted in the cycle its predecessor's result
//  is shown. Reset clears every ticket at once, so the block is ready as
//  soon as reset is released. The receiver cannot stall; busy holds off
//  the sender during a scan.
//
`default_nettype none

module bakery_ticket_arbiter #(
    parameter int PARTIES    = bta_pkg::DEF_PARTIES,
    parameter int TICKET_MAX = bta_pkg::DEF_TICKET_MAX
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire                          req_type,
    input  wire  [bta_pkg::PARTY_W-1:0]  party_id,
    output logic                         done,
    output logic [bta_pkg::GIVEN_W-1:0]  ticket_given,
    output logic                         refused,
    output logic                         holder_valid,
    output logic [bta_pkg::PARTY_W-1:0]  holder_id
);
    import bta_pkg::*;

    `include "bakery_ticket_arbiter_macros.svh"

    localparam int TW = $clog2(TICKET_MAX + 1);
    localparam int IW = $clog2(PARTIES);
    localparam logic [TW:0] TMAX = (TW + 1)'(TICKET_MAX);

    // The scan word: a control part plus three running folds (largest
    // ticket, smallest nonzero ticket overall, and smallest nonzero ticket
    // of every party but the one issuing the event).
    pass_ctl_t     ctl_chain     [PARTIES+1];
    logic [TW-1:0] max_chain     [PARTIES+1];
    logic [TW-1:0] mina_chain    [PARTIES+1];
    logic [IW-1:0] mina_id_chain [PARTIES+1];
    logic [TW-1:0] minx_chain    [PARTIES+1];
    logic [IW-1:0] minx_id_chain [PARTIES+1];

    state_t state_reg, state_next;

    logic                done_reg;
    logic [GIVEN_W-1:0]  given_reg;
    logic                refused_reg;
    logic                hvalid_reg;
    logic [PARTY_W-1:0]  hid_reg;

    pass_ctl_t           tail;
    logic                accept;
    logic                in_range;
    logic [TW:0]         top_plus;
    logic                over;
    logic                grant;
    logic                wr_en;
    logic [TW-1:0]       wr_value;
    logic                hvalid_next;
    logic [PARTY_W-1:0]  hid_next;

    // The event enters the first cell straight from the ports, with empty folds.
    assign accept              = start && !busy;
    assign ctl_chain[0].valid  = accept;
    assign ctl_chain[0].is_rel = req_type;
    assign ctl_chain[0].party  = party_id;
    assign max_chain[0]        = '0;
    assign mina_chain[0]       = '0;
    assign mina_id_chain[0]    = '0;
    assign minx_chain[0]       = '0;
    assign minx_id_chain[0]    = '0;

    for (genvar i = 0; i < PARTIES; i++)
    begin : g_cell
        bta_cell #(
            .TW      (TW),
            .IW      (IW),
            .CELL_ID (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl_in      (ctl_chain[i]),
            .max_in      (max_chain[i]),
            .mina_in     (mina_chain[i]),
            .mina_id_in  (mina_id_chain[i]),
            .minx_in     (minx_chain[i]),
            .minx_id_in  (minx_id_chain[i]),
            .ctl_out     (ctl_chain[i+1]),
            .max_out     (max_chain[i+1]),
            .mina_out    (mina_chain[i+1]),
            .mina_id_out (mina_id_chain[i+1]),
            .minx_out    (minx_chain[i+1]),
            .minx_id_out (minx_id_chain[i+1]),
            .wr_en       (wr_en),
            .wr_party    (tail.party),
            .wr_value    (wr_value)
        );
    end

    assign tail = ctl_chain[PARTIES];

    // Resolve the event once the word leaves the last cell. A granted ticket
    // is above every other one, so it only becomes the holder when no other
    // party holds a ticket; a refusal or an ignored event leaves the store
    // as it was, so the overall minimum stands.
    always_comb
    begin
        in_range    = (32'(tail.party) < PARTIES);
        top_plus    = {1'b0, max_chain[PARTIES]} + (TW + 1)'(1);
        over        = (top_plus > TMAX);
        grant       = in_range && !tail.is_rel && !over;
        wr_en       = tail.valid && in_range && (tail.is_rel || !over);
        wr_value    = tail.is_rel ? '0 : top_plus[TW-1:0];
        hvalid_next = mina_chain[PARTIES] != '0;
        hid_next    = PARTY_W'(mina_id_chain[PARTIES]);
        if (in_range && (tail.is_rel || !over))
        begin
            if (minx_chain[PARTIES] != '0)
            begin
                hvalid_next = 1'b1;
                hid_next    = PARTY_W'(minx_id_chain[PARTIES]);
            end
            else if (grant)
            begin
                hvalid_next = 1'b1;
                hid_next    = tail.party;
            end
            else
            begin
                hvalid_next = 1'b0;
                hid_next    = '0;
            end
        end
        if (!hvalid_next)
        begin
            hid_next = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE: busy = 1'b0;
            ST_SCAN: busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            given_reg   <= grant ? GIVEN_W'(top_plus[TW-1:0]) : '0;
            refused_reg <= in_range && !tail.is_rel && over;
            hvalid_reg  <= hvalid_next;
            hid_reg     <= hid_next;
        end
    end

    assign done         = done_reg;
    assign ticket_given = given_reg;
    assign refused      = refused_reg;
    assign holder_valid = hvalid_reg;
    assign holder_id    = hid_reg;

    `BTA_ASSERT_NXT(a_accept_busy, accept, busy, "accepted event did not start a scan")
    `BTA_ASSERT_IMP(a_tail_in_scan, tail.valid, state_reg == ST_SCAN, "scan word outside scan")
    `BTA_ASSERT_NXT(a_tail_done, tail.valid, done, "scan finished without a result")
    `BTA_ASSERT_IMP(a_refuse_zero, done && refused, ticket_given == '0, "refusal gave a ticket")
    `BTA_ASSERT_IMP(a_no_holder, done && !holder_valid, holder_id == '0, "holder id without holder")

endmodule

`default_nettype wire

// File: tb/bakery_ticket_arbiter_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Bakery ticket arbiter testbench
// Drives take-ticket and release words into the arbiter and checks every
// result word against a cycle-free model of the ticket store kept here.
// ---------------------------------------------------------------------------

module bakery_ticket_arbiter_test;

    import bta_pkg::*;

    // The block is built at its default size, so the model uses the same numbers.
    localparam int PARTIES     = DEF_PARTIES;
    localparam int TICKET_MAX  = DEF_TICKET_MAX;
    localparam int SCAN_CYCLES = PARTIES + 1;
    // The slowest correct run drives roughly 520 words, one full scan each.
    // This limit allows for several times that.
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;

    // These are the codes of the req_type field.
    localparam logic EV_TAKE    = 1'b0;
    localparam logic EV_RELEASE = 1'b1;

    // One event word waits here before it is driven. When hold_for_drain is
    // set, the driver keeps the word back until every result owed so far
    // has come out of the block.
    typedef struct {
        logic               kind;
        logic [PARTY_W-1:0] who;
        bit                 hold_for_drain;
    } ticket_event_t;

    // This is one result word as the model predicts it.
    typedef struct {
        logic [GIVEN_W-1:0] ticket;
        logic               refused;
        logic               holder_valid;
        logic [PARTY_W-1:0] holder_id;
    } arbiter_answer_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               start    = 1'b0;
    logic               req_type = EV_TAKE;
    logic [PARTY_W-1:0] party_id = '0;
    wire                busy;
    wire                done;
    wire  [GIVEN_W-1:0] ticket_given;
    wire                refused;
    wire                holder_valid;
    wire  [PARTY_W-1:0] holder_id;

    ticket_event_t   ticket_events[$];
    arbiter_answer_t owed_answers[$];
    int unsigned     ticket_book[PARTIES];

    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned issued_count  = 0;
    int unsigned total_events  = 0;
    int unsigned checked_count = 0;
    int unsigned grant_count   = 0;
    int unsigned refusal_count = 0;
    int unsigned release_count = 0;
    int unsigned top_ticket    = 0;

    bakery_ticket_arbiter #(
        .PARTIES    (PARTIES),
        .TICKET_MAX (TICKET_MAX)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .party_id     (party_id),
        .done         (done),
        .ticket_given (ticket_given),
        .refused      (refused),
        .holder_valid (holder_valid),
        .holder_id    (holder_id)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The run stops here if the block hangs or slows down far beyond its
    // specified rate.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still owed.",
                     cycle_count, owed_answers.size());
            $display("bakery_ticket_arbiter_test: errors");
            $finish;
        end
    end

    // This task prints one line for each mismatch and counts every one. After
    // a burst of errors it stops printing so the log stays readable.
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    // This function applies one event to the local ticket store and returns
    // the result word that the block must produce for it. A take gives one
    // more than the largest ticket held, the caller's own included. If that
    // would pass TICKET_MAX, the take is refused and the store is left as it
    // is. A release clears the ticket, and it does nothing if none is held.
    // The holder is the party with the smallest nonzero ticket. Tickets are
    // unique, so a tie cannot happen. The scan still favors the lower id.
    function automatic arbiter_answer_t serve_ticket_event(input logic kind,
                                                           input logic [PARTY_W-1:0] who);
        arbiter_answer_t ans;
        int unsigned     top;
        int unsigned     lowest;
        ans = '{ticket: '0, refused: 1'b0, holder_valid: 1'b0, holder_id: '0};
        if (int'(who) < PARTIES)
        begin
            if (kind == EV_TAKE)
            begin
                top = 0;
                for (int i = 0; i < PARTIES; i++)
                begin
                    if (ticket_book[i] > top)
                        top = ticket_book[i];
                end
                if (top + 1 > TICKET_MAX)
                begin
                    ans.refused = 1'b1;
                    refusal_count++;
                end
                else
                begin
                    ticket_book[who] = top + 1;
                    ans.ticket       = GIVEN_W'(top + 1);
                    grant_count++;
                    if (top + 1 > top_ticket)
                        top_ticket = top + 1;
                end
            end
            else
            begin
                ticket_book[who] = 0;
                release_count++;
            end
        end
        lowest = 0;
        for (int i = 0; i < PARTIES; i++)
        begin
            if (ticket_book[i] != 0 && (lowest == 0 || ticket_book[i] < lowest))
            begin
                lowest        = ticket_book[i];
                ans.holder_id = PARTY_W'(i);
            end
        end
        ans.holder_valid = (lowest != 0);
        return ans;
    endfunction

    // This is the driver. At each rising edge it first notes whether the
    // current word was taken (start high, busy low), and if so it records
    // the predicted answer. While the slot is free it then either presents
    // the next word or idles. The idle rate follows the run: 34 percent for
    // the first third of the words, 57 percent for the second third, and
    // none for the rest. A word marked hold_for_drain waits until nothing is
    // owed. Checking done as well keeps that test clear of the monitor
    // popping its queue at the same edge.
    always @(posedge clk)
    begin
        ticket_event_t nxt;
        int unsigned   idle_pct;
        if (rst_n)
        begin
            if (start && !busy)
                owed_answers.push_back(serve_ticket_event(req_type, party_id));
            if (!start || !busy)
            begin
                if (issued_count * 3 < total_events)
                    idle_pct = 34;
                else if (issued_count * 3 < total_events * 2)
                    idle_pct = 57;
                else
                    idle_pct = 0;
                if (ticket_events.size() != 0
                    && !(ticket_events[0].hold_for_drain
                         && (owed_answers.size() != 0 || done))
                    && $urandom_range(99) >= idle_pct)
                begin
                    nxt = ticket_events.pop_front();
                    start    <= 1'b1;
                    req_type <= nxt.kind;
                    party_id <= nxt.who;
                    issued_count++;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // This is the monitor. Each done strobe carries one result word. It is
    // checked field by field against the oldest answer still owed.
    always @(posedge clk)
    begin
        arbiter_answer_t want;
        if (rst_n && done)
        begin
            if (owed_answers.size() == 0)
            begin
                report_mismatch($sformatf("result word with no event pending: ticket %0d",
                                          ticket_given));
            end
            else
            begin
                want = owed_answers.pop_front();
                checked_count++;
                if (ticket_given !== want.ticket)
                    report_mismatch($sformatf("ticket_given %0d, expected %0d",
                                              ticket_given, want.ticket));
                if (refused !== want.refused)
                    report_mismatch($sformatf("refused %b, expected %b",
                                              refused, want.refused));
                if (holder_valid !== want.holder_valid)
                    report_mismatch($sformatf("holder_valid %b, expected %b",
                                              holder_valid, want.holder_valid));
                if (holder_id !== want.holder_id)
                    report_mismatch($sformatf("holder_id %0d, expected %0d",
                                              holder_id, want.holder_id));
            end
        end
    end

    task automatic queue_event(input logic kind, input logic [PARTY_W-1:0] who,
                               input bit hold_for_drain);
        ticket_events.push_back('{kind: kind, who: who, hold_for_drain: hold_for_drain});
    endtask

    initial
    begin
        int unsigned        order[PARTIES];
        int unsigned        pick;
        int unsigned        swap_tmp;
        logic [PARTY_W-1:0] who;

        foreach (ticket_book[i])
            ticket_book[i] = 0;

        // The directed words come first. They cover a release with no holder
        // and no ticket, a first take, a take by the highest id, and a take
        // by a party that already holds a ticket, which moves it to the back
        // of the line. They also cover releases that hand the lead to the
        // next party and patterns that toggle every bit of party_id.
        queue_event(EV_RELEASE, 5'd0,  1'b0);
        queue_event(EV_TAKE,    5'd0,  1'b0);
        queue_event(EV_TAKE,    5'd31, 1'b0);
        queue_event(EV_TAKE,    5'd0,  1'b0);
        queue_event(EV_RELEASE, 5'd31, 1'b0);
        queue_event(EV_RELEASE, 5'd0,  1'b0);
        queue_event(EV_TAKE,    5'd16, 1'b0);
        queue_event(EV_TAKE,    5'd15, 1'b0);
        queue_event(EV_TAKE,    5'd15, 1'b0);
        queue_event(EV_RELEASE, 5'd16, 1'b0);
        queue_event(EV_TAKE,    5'd10, 1'b0);
        queue_event(EV_TAKE,    5'd21, 1'b0);
        queue_event(EV_RELEASE, 5'd15, 1'b0);
        queue_event(EV_RELEASE, 5'd10, 1'b0);
        queue_event(EV_RELEASE, 5'd21, 1'b0);

        // In the climb, almost every word is a take. The largest ticket then
        // rises to TICKET_MAX, and from there on most takes are refused.
        // The rare release of the last party to take lets one more ticket be
        // granted. The climb also runs every ticket value through the field.
        for (int n = 0; n < 320; n++)
            queue_event(($urandom_range(99) < 92) ? EV_TAKE : EV_RELEASE,
                        PARTY_W'($urandom_range(PARTIES - 1)), 1'b0);

        // The drain releases every party once, in shuffled order, so the
        // lead passes down the line until nobody is left. Its first word
        // waits until every owed result has come out.
        foreach (order[i])
            order[i] = i;
        for (int i = PARTIES - 1; i > 0; i--)
        begin
            pick        = $urandom_range(i);
            swap_tmp    = order[i];
            order[i]    = order[pick];
            order[pick] = swap_tmp;
        end
        foreach (order[i])
            queue_event(EV_RELEASE, PARTY_W'(order[i]), i == 0);

        // The mixed part uses a balanced mix of takes and releases. Half of
        // its words come from a few parties, so repeat takes and releases by
        // the current holder are common.
        for (int n = 0; n < 150; n++)
        begin
            if ($urandom_range(1) == 0)
                who = PARTY_W'($urandom_range(3)) ^ {PARTY_W{n[0]}};
            else
                who = PARTY_W'($urandom_range(PARTIES - 1));
            queue_event(($urandom_range(99) < 55) ? EV_TAKE : EV_RELEASE, who, n == 0);
        end
        total_events = ticket_events.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Sampling on the falling edge keeps these waits clear of the
        // queue updates made at the rising edge.
        while (ticket_events.size() != 0 || start || owed_answers.size() != 0)
            @(negedge clk);
        repeat (2 * SCAN_CYCLES) @(negedge clk);

        $display("Ran %0d event words, checked %0d results: %0d grants, %0d refusals,",
                 total_events, checked_count, grant_count, refusal_count);
        $display("%0d releases, highest ticket granted %0d.", release_count, top_ticket);
        if (error_count == 0)
            $display("bakery_ticket_arbiter_test: clean");
        else
            $display("bakery_ticket_arbiter_test: errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/bta_pkg.sv
rtl/bta_cell.sv
rtl/bakery_ticket_arbiter.sv
tb/bakery_ticket_arbiter_test.sv
